>>> rtl/sst_pkg.sv
`timescale 1ns / 1ps
package sst_pkg;

  localparam int CAPACITY_MAX = 32;
  localparam int VALUE_BITS   = 32;
  localparam int CNT_W        = $clog2(CAPACITY_MAX + 1);
  localparam int COUNT_W      = 6;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_TEST   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_ABSENT    = 2'd3;

  // commands broadcast from the control to every cell
  typedef struct packed {
    logic                  do_insert;
    logic                  do_remove;
    logic [VALUE_BITS-1:0] key;
  } cell_ctl_t;

endpackage

>>> rtl/small_set_table_top.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields (lowest bit first)                | tuser / tlast
// s_*     | in  | mode [1:0], value [33:2], zero pad [39:34]      | none
// m_*     | out | found [0], status [2:1], count [8:3], pad [15:9] | none
//
// each transaction is accepted in idle, then in execute every cell compares
// its entry against the key at once and the row shifts or appends.
// the prefix-or hit chain across the row of cells sets the execute cycle.
// the result sits in an output register, so the next transaction is accepted
// while it waits; execute holds while that register is still full.
// rst (synchronous) empties the set; entry storage itself is not cleared.
module small_set_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode, value, pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // found, status, count, pad
);
  import sst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                state, state_next;
  logic [1:0]            mode_q;
  logic [VALUE_BITS-1:0] key_q;
  logic [CNT_W-1:0]      fill_count, fill_count_next;

  logic                  found_q;
  logic [1:0]            status_q;
  logic [COUNT_W-1:0]    count_q;

  logic [VALUE_BITS-1:0] entry [CAPACITY_MAX];
  logic                  hit   [CAPACITY_MAX+1];
  cell_ctl_t             ctl;

  logic found, full, exec_done, is_insert, is_remove;
  logic [1:0] status;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {7'd0, count_q, status_q, found_q};

  // row of cells, hit ripples from the head toward the tail
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY_MAX; i++) begin : g_cell
    logic [VALUE_BITS-1:0] nbr;
    if (i == CAPACITY_MAX - 1) begin : g_last
      assign nbr = entry[i];
    end else begin : g_mid
      assign nbr = entry[i+1];
    end
    sst_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .used      (fill_count > CNT_W'(i)),
      .tail      (fill_count == CNT_W'(i)),
      .hit_in    (hit[i]),
      .nbr_entry (nbr),
      .entry     (entry[i]),
      .hit_out   (hit[i+1])
    );
  end

  assign found     = hit[CAPACITY_MAX];
  assign full      = (fill_count == CNT_W'(CAPACITY_MAX));
  assign is_insert = (mode_q == MODE_INSERT);
  assign is_remove = (mode_q == MODE_REMOVE);
  // execute only once the output register can take the result
  assign exec_done = (state == S_EXEC) && (!m_tvalid || m_tready);

  always_comb begin
    status = ST_OK;
    if (is_insert) begin
      if (full) begin
        status = ST_FULL;
      end else if (found) begin
        status = ST_DUPLICATE;
      end
    end else if (is_remove) begin
      if (!found) begin
        status = ST_ABSENT;
      end
    end
  end

  always_comb begin
    ctl.key       = key_q;
    ctl.do_insert = exec_done && is_insert && (status == ST_OK);
    ctl.do_remove = exec_done && is_remove && (status == ST_OK);
  end

  always_comb begin
    fill_count_next = fill_count;
    if (ctl.do_insert) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (ctl.do_remove) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (exec_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      if (exec_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mode_q <= s_tdata[1:0];
      key_q  <= s_tdata[VALUE_BITS+1:2];
    end
    if (exec_done) begin
      found_q  <= found;
      status_q <= status;
      count_q  <= COUNT_W'(fill_count_next);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY_MAX))
    else $error("fill count beyond capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !exec_done |=> $stable(fill_count))
    else $error("fill count changed outside execute");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.do_insert |=> fill_count == $past(fill_count) + CNT_W'(1))
    else $error("insert did not grow the set");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status_q == ST_FULL |-> count_q == COUNT_W'(CAPACITY_MAX))
    else $error("full status with set not full");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    exec_done |=> m_tvalid && state == S_IDLE)
    else $error("execute left no result");

endmodule

>>> rtl/sst_cell.sv
`timescale 1ns / 1ps
module sst_cell (
  input  logic                          clk,
  input  sst_pkg::cell_ctl_t            ctl,
  input  logic                          used,
  input  logic                          tail,
  input  logic                          hit_in,
  input  logic [sst_pkg::VALUE_BITS-1:0] nbr_entry,
  output logic [sst_pkg::VALUE_BITS-1:0] entry,
  output logic                          hit_out
);
  import sst_pkg::*;

  logic match;

  assign match   = used && (entry == ctl.key);
  assign hit_out = hit_in | match;

  // on remove, cells at or after the removed entry take the neighbor's value; on insert, the tail takes the key
  always_ff @(posedge clk) begin
    if (ctl.do_remove && hit_out) begin
      entry <= nbr_entry;
    end else if (ctl.do_insert && tail) begin
      entry <= ctl.key;
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sst_pkg::*;

  // mode 3 is not a named operation; the block treats it as a lookup
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int RAND_ITEMS = 1500;
  localparam int CALM_TAIL  = 200;   // last transactions run with no idling
  localparam int POOL_N     = 40;
  localparam int QUIET_MAX  = 4000;  // cycles with no transaction on either side
  localparam int LONG_HOLD  = 90;

  typedef struct packed {
    logic               found;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } set_reply_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] value;
    int          reps;   // value is stepped by one on each repeat
    bit          typed;  // reply typed in below rather than predicted
    set_reply_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  small_set_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the set, kept in acceptance order
  logic [VALUE_BITS-1:0] set_entries [CAPACITY_MAX];
  int                    set_fill = 0;
  set_reply_t            replies_due [$];

  int  errors = 0;
  int  n_sent = 0;
  int  n_full = 0;
  int  n_dup = 0;
  int  n_absent = 0;
  int  n_hit = 0;
  int  peak_fill = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  // applies one request to the shadow set and returns the reply it must give
  function automatic set_reply_t set_apply(input logic [1:0] m, input logic [31:0] v);
    set_reply_t r;
    int pos;
    pos = set_fill;
    for (int i = 0; i < set_fill; i++) begin
      if (pos == set_fill && set_entries[i] == v[VALUE_BITS-1:0]) pos = i;
    end
    r.found  = (pos < set_fill);
    r.status = ST_OK;
    case (m)
      MODE_INSERT: begin
        // the full check wins over the duplicate check
        if (set_fill >= CAPACITY_MAX) begin
          r.status = ST_FULL;
        end else if (r.found) begin
          r.status = ST_DUPLICATE;
        end else begin
          set_entries[set_fill] = v[VALUE_BITS-1:0];
          set_fill++;
        end
      end
      MODE_REMOVE: begin
        if (!r.found) begin
          r.status = ST_ABSENT;
        end else begin
          // close the gap: later entries move down one place
          for (int i = pos; i + 1 < set_fill; i++) set_entries[i] = set_entries[i + 1];
          set_fill--;
        end
      end
      default: ;  // lookup and the spare mode leave the set alone
    endcase
    r.count = set_fill[COUNT_W-1:0];
    if (r.found) n_hit++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_DUPLICATE) n_dup++;
    if (r.status == ST_ABSENT) n_absent++;
    if (set_fill > peak_fill) peak_fill = set_fill;
    return r;
  endfunction

  // directed opening: typed replies only where they are obvious
  dir_row_t dir_rows [22] = '{
    '{MODE_TEST,   32'h0000_0000, 1,  1'b1, '{1'b0, ST_OK,        6'd0}},
    '{MODE_REMOVE, 32'h0000_0000, 1,  1'b1, '{1'b0, ST_ABSENT,    6'd0}},
    '{MODE_INSERT, 32'h0000_0000, 1,  1'b1, '{1'b0, ST_OK,        6'd1}},
    '{MODE_INSERT, 32'h0000_0000, 1,  1'b1, '{1'b1, ST_DUPLICATE, 6'd1}},
    '{MODE_INSERT, 32'hFFFF_FFFF, 1,  1'b1, '{1'b0, ST_OK,        6'd2}},
    '{MODE_TEST,   32'hFFFF_FFFF, 1,  1'b1, '{1'b1, ST_OK,        6'd2}},
    '{MODE_SPARE,  32'h0000_0000, 1,  1'b1, '{1'b1, ST_OK,        6'd2}},
    '{MODE_INSERT, 32'h5555_5555, 1,  1'b0, '{1'b0, ST_OK,        6'd0}},
    '{MODE_INSERT, 32'hAAAA_AAAA, 1,  1'b0, '{1'b0, ST_OK,        6'd0}},
    // drop the head entry, everything behind it shifts
    '{MODE_REMOVE, 32'h0000_0000, 1,  1'b0, '{1'b0, ST_OK,        6'd0}},
    '{MODE_TEST,   32'hAAAA_AAAA, 1,  1'b0, '{1'b0, ST_OK,        6'd0}},
    '{MODE_SPARE,  32'h0000_1234, 1,  1'b0, '{1'b0, ST_OK,        6'd0}},
    // fill to capacity
    '{MODE_INSERT, 32'h0000_0100, 29, 1'b0, '{1'b0, ST_OK,        6'd0}},
    '{MODE_INSERT, 32'h0000_0999, 1,  1'b1, '{1'b0, ST_FULL,      6'd32}},
    // present value into a full set still reports full
    '{MODE_INSERT, 32'h5555_5555, 1,  1'b1, '{1'b1, ST_FULL,      6'd32}},
    '{MODE_REMOVE, 32'hFFFF_FFFF, 1,  1'b0, '{1'b0, ST_OK,        6'd0}},
    '{MODE_REMOVE, 32'h0000_011C, 1,  1'b0, '{1'b0, ST_OK,        6'd0}},
    '{MODE_TEST,   32'h0000_0101, 1,  1'b0, '{1'b0, ST_OK,        6'd0}},
    '{MODE_REMOVE, 32'h0000_0999, 1,  1'b1, '{1'b0, ST_ABSENT,    6'd30}},
    '{MODE_INSERT, 32'h0000_0999, 1,  1'b0, '{1'b0, ST_OK,        6'd0}},
    '{MODE_REMOVE, 32'h5555_5555, 1,  1'b0, '{1'b0, ST_OK,        6'd0}},
    '{MODE_TEST,   32'h0000_011C, 1,  1'b0, '{1'b0, ST_OK,        6'd0}}
  };

  // one request transaction; the shadow set advances at the accepting edge
  task automatic send_request(input logic [1:0] m, input logic [31:0] v,
                              input bit typed, input set_reply_t want);
    set_reply_t pred;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, v, m};
    do @(posedge clk); while (!s_tready);
    pred = set_apply(m, v);
    replies_due.push_back(typed ? want : pred);
    n_sent++;
    if (idle_on && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // sender stops until every reply in flight has come back
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // reply side: check each transaction, stall in random bursts
  initial begin
    set_reply_t want;
    int stall_left;
    bit hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: reply with nothing expected, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          want = replies_due.pop_front();
          check_field("found",  want.found,  m_tdata[0]);
          check_field("status", want.status, m_tdata[2:1]);
          check_field("count",  want.count,  m_tdata[8:3]);
        end
      end
      if (hold_req && !hold_taken) begin
        // long hold-off so the block backs up into its input
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction at all
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_MAX);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // stimulus
  initial begin
    logic [31:0] pool [POOL_N];
    logic [31:0] v;
    logic [1:0]  m;
    int ins_w;
    int rem_w;
    int plen;
    int phase;
    int r;
    int rand_sent;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      for (int j = 0; j < dir_rows[k].reps; j++) begin
        send_request(dir_rows[k].mode, dir_rows[k].value + j, dir_rows[k].typed,
                     dir_rows[k].want);
      end
    end
    drain_replies();

    // random phases, each with its own value pool and operation mix
    rand_sent = 0;
    phase = 0;
    while (rand_sent < RAND_ITEMS) begin
      plen = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0: begin ins_w = 65; rem_w = 15; end  // grows toward full
        1: begin ins_w = 20; rem_w = 65; end  // drains toward empty
        default: begin ins_w = 40; rem_w = 35; end
      endcase
      // about a quarter of each pool's values are narrow so hits and duplicates are frequent
      for (int i = 0; i < POOL_N; i++) begin
        pool[i] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 63)) : $urandom;
      end
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        idle_on  = 1'b0;
        hold_req = 1'b1;
      end
      for (int n = 0; n < plen && rand_sent < RAND_ITEMS; n++) begin
        if (rand_sent >= RAND_ITEMS - CALM_TAIL) idle_on = 1'b0;
        r = $urandom_range(0, 99);
        if (r < ins_w) m = MODE_INSERT;
        else if (r < ins_w + rem_w) m = MODE_REMOVE;
        else if (r < 96) m = MODE_TEST;
        else m = MODE_SPARE;
        r = $urandom_range(0, 99);
        if (r < 50 && set_fill > 0) begin
          v = set_entries[$urandom_range(0, set_fill - 1)];
        end else if (r < 88) begin
          v = pool[$urandom_range(0, POOL_N - 1)];
        end else begin
          case ($urandom_range(0, 3))
            0: v = 32'h0000_0000;
            1: v = 32'hFFFF_FFFF;
            default: v = $urandom;
          endcase
        end
        send_request(m, v, 1'b0, '0);
        rand_sent++;
      end
      if (phase == 4 || $urandom_range(0, 4) == 0) drain_replies();
      phase++;
    end

    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    // keep running to catch any stray reply
    repeat (20) @(posedge clk);

    $display("ran %0d requests: %0d hits, %0d full, %0d duplicate, %0d absent rejects",
             n_sent, n_hit, n_full, n_dup, n_absent);
    $display("set reached %0d of %0d entries; long reply stall and drain pauses included",
             peak_fill, CAPACITY_MAX);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
